// File: rtl/tsc_pkg.sv
// Shared constants, types and codes of the triggered scope capture block.
`default_nettype none
package tsc_pkg;
    localparam int DEPTH    = 8192;
    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = AW + 1;
    localparam int SW       = 24;
    localparam int COL_W    = 12;
    localparam int CCNT_W   = 13;
    localparam int DIV_W    = 26;
    localparam int DIV_CW   = $clog2(DIV_W);
    localparam int CFG_IW   = 3;

    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_COLUMN = 2'd1;
    localparam logic [1:0] REQ_POINT  = 2'd2;
    localparam logic [1:0] REQ_WINDOW = 2'd3;

    localparam logic [CFG_IW-1:0] CFG_LEVEL   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_CHANNEL = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_FALLING = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_WINDOW  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_FREEZE  = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_COLUMNS = 3'd5;

    typedef struct packed {
        logic [1:0]        req_type;
        logic signed [SW-1:0] sample_a;
        logic signed [SW-1:0] sample_b;
        logic              channel;
        logic [COL_W-1:0]  column;
        logic [AW-1:0]     point_index;
    } t_item;

    typedef struct packed {
        logic signed [SW-1:0] level;
        logic              channel;
        logic              falling;
        logic [CW-1:0]     window;
        logic              freeze;
        logic [CCNT_W-1:0] columns;
    } t_cfg;
endpackage
`default_nettype wire

// File: rtl/tsc_front.sv
// Front end: accepts requests, drops frozen pushes and queues the rest.
`default_nettype none
module tsc_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire tsc_pkg::t_item i_item,
    input  wire logic           i_freeze,
    output logic                o_q_valid,
    output tsc_pkg::t_item      o_q_item,
    input  wire logic           i_q_pop
);
    tsc_pkg::t_item r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       acc, keep;

    assign o_ready   = (r_cnt != 2'd2);
    assign acc       = i_valid && o_ready;
    // A push while frozen is taken and discarded.
    assign keep      = acc && !(i_item.req_type == tsc_pkg::REQ_PUSH && i_freeze);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_mem[r_wr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (keep) r_wr <= ~r_wr;
            if (i_q_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, keep} - {1'b0, i_q_pop};
        end
    end
endmodule
`default_nettype wire

// File: rtl/tsc_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tsc_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [tsc_pkg::DIV_W-1:0]    i_dividend,
    input  wire logic [tsc_pkg::CCNT_W-1:0]   i_divisor,
    output logic                              o_done,
    output logic [tsc_pkg::DIV_W-1:0]         o_quot
);
    logic                            r_busy, r_done;
    logic [tsc_pkg::DIV_CW-1:0]      r_cnt;
    logic [tsc_pkg::CCNT_W-1:0]      r_rem;
    logic [tsc_pkg::DIV_W-1:0]       r_quot;
    logic [tsc_pkg::CCNT_W:0]        rem_sh, rem_sub;
    logic                            ge;
    logic                            last_bit;

    assign rem_sh   = {r_rem, r_quot[tsc_pkg::DIV_W-1]};
    assign ge       = rem_sh >= {1'b0, i_divisor};
    assign rem_sub  = rem_sh - {1'b0, i_divisor};
    assign last_bit = r_busy && (r_cnt == tsc_pkg::DIV_CW'(tsc_pkg::DIV_W - 1));
    assign o_done   = r_done;
    assign o_quot   = r_quot;

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            r_rem  <= ge ? rem_sub[tsc_pkg::CCNT_W-1:0] : rem_sh[tsc_pkg::CCNT_W-1:0];
            r_quot <= {r_quot[tsc_pkg::DIV_W-2:0], ge};
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= last_bit;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_bit) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/tsc_back.sv
// Back end: sample stores, trigger logic, query execution and result register.
`default_nettype none
module tsc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tsc_pkg::t_cfg  i_cfg,
    input  wire logic           i_q_valid,
    input  wire tsc_pkg::t_item i_q_item,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic signed [tsc_pkg::SW-1:0] o_min_value,
    output logic signed [tsc_pkg::SW-1:0] o_max_value,
    output logic signed [tsc_pkg::SW-1:0] o_point_a,
    output logic signed [tsc_pkg::SW-1:0] o_point_b,
    output logic [tsc_pkg::CW-1:0]        o_window_length,
    output logic                          o_capture_valid
);
    localparam int AW = tsc_pkg::AW;
    localparam int CW = tsc_pkg::CW;
    localparam int SW = tsc_pkg::SW;
    localparam int DW = tsc_pkg::DIV_W;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DIV_LO = 7'b0000010,
        ST_DIV_HI = 7'b0000100,
        ST_SCAN   = 7'b0001000,
        ST_TAIL   = 7'b0010000,
        ST_PREAD  = 7'b0100000,
        ST_RESP   = 7'b1000000
    } t_state;

    logic signed [SW-1:0] mem_a [tsc_pkg::DEPTH];
    logic signed [SW-1:0] mem_b [tsc_pkg::DEPTH];

    t_state r_state;
    tsc_pkg::t_item r_item;
    logic [AW-1:0] r_wp, r_tp;
    logic [CW-1:0] r_fill, r_ws;
    logic r_above, r_have;
    logic signed [SW-1:0] r_qa, r_qb, r_mn, r_mx, r_pa, r_pb;
    logic r_rd_ok, r_rd_vld, r_first;
    logic [DW-1:0] r_off, r_end;
    logic r_out_vld;
    logic signed [SW-1:0] r_o_mn, r_o_mx, r_o_pa, r_o_pb;
    logic [CW-1:0] r_o_wl;
    logic r_o_cv;

    logic pop, is_push;
    logic [CW-1:0] fill_inc, w_clamp;
    logic signed [SW-1:0] watched, v_fold;
    logic above, trig;
    logic [DW-1:0] rd_off, wm1;
    logic [AW-1:0] off13, rd_idx;
    logic rd_ok;
    logic div_start, div_done;
    logic [DW-1:0] div_quot, div_dvd;
    logic [DW:0] prod;
    logic [DW-1:0] end_raw, end_b;
    logic out_free;

    assign pop     = (r_state == ST_IDLE) && i_q_valid;
    assign o_q_pop = pop;
    assign is_push = i_q_item.req_type == tsc_pkg::REQ_PUSH;
    assign out_free = !r_out_vld || i_out_ready;

    // Push side: fill count, crossing test, window clamp.
    assign fill_inc = (r_fill < CW'(tsc_pkg::DEPTH)) ? r_fill + 1'b1 : r_fill;
    assign watched  = i_cfg.channel ? i_q_item.sample_b : i_q_item.sample_a;
    assign above    = watched >= i_cfg.level;
    assign trig     = i_cfg.falling ? (!above && r_above) : (above && !r_above);
    always_comb begin
        w_clamp = i_cfg.window;
        if (w_clamp == '0) w_clamp = CW'(1);
        if (w_clamp > CW'(tsc_pkg::DEPTH)) w_clamp = CW'(tsc_pkg::DEPTH);
    end

    // Read address: window offset clamped to the last sample, then mapped
    // into the ring. An entry never written since reset reads as zero.
    assign rd_off = (r_state == ST_IDLE) ? DW'(i_q_item.point_index) : r_off;
    assign wm1    = DW'(r_ws) - 1'b1;
    assign off13  = (rd_off > wm1) ? wm1[AW-1:0] : rd_off[AW-1:0];
    assign rd_idx = r_tp - r_ws[AW-1:0] + off13;
    assign rd_ok  = CW'(rd_idx) < r_fill;

    // Column bounds: start = col*w/cc, end = (col+1)*w/cc.
    always_comb begin
        if (r_state == ST_IDLE)
            prod = (DW+1)'({1'b0, i_q_item.column} * r_ws);
        else
            prod = (DW+1)'(({1'b0, r_item.column} + 1'b1) * r_ws);
    end
    assign div_dvd   = prod[DW-1:0];
    assign div_start = (pop && i_q_item.req_type == tsc_pkg::REQ_COLUMN && r_have
                        && i_cfg.columns != '0)
                       || (r_state == ST_DIV_LO && div_done);

    tsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (i_cfg.columns),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign end_raw = div_quot;
    always_comb begin
        if (end_raw < r_off + 1'b1) end_b = r_off + 1'b1;
        else if (end_raw > DW'(r_ws)) end_b = DW'(r_ws);
        else end_b = end_raw;
    end

    assign v_fold = r_rd_ok ? (r_item.channel ? r_qb : r_qa) : '0;

    always_ff @(posedge i_clk) begin
        if (pop && is_push) begin
            mem_a[r_wp] <= i_q_item.sample_a;
            mem_b[r_wp] <= i_q_item.sample_b;
        end
        r_qa    <= mem_a[rd_idx];
        r_qb    <= mem_b[rd_idx];
        r_rd_ok <= rd_ok;
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_item <= i_q_item;
            r_mn <= '0;
            r_mx <= '0;
            r_pa <= '0;
            r_pb <= '0;
        end
        if (r_state == ST_DIV_LO && div_done) r_off <= div_quot;
        if (r_state == ST_DIV_HI && div_done) r_end <= end_b;
        if (r_state == ST_SCAN) r_off <= r_off + 1'b1;
        if (r_rd_vld) begin
            if (r_first || v_fold < r_mn) r_mn <= v_fold;
            if (r_first || v_fold > r_mx) r_mx <= v_fold;
        end
        if (r_state == ST_PREAD) begin
            r_pa <= r_rd_ok ? r_qa : '0;
            r_pb <= r_rd_ok ? r_qb : '0;
        end
        if (r_state == ST_RESP && out_free) begin
            r_o_mn <= r_mn;
            r_o_mx <= r_mx;
            r_o_pa <= r_pa;
            r_o_pb <= r_pb;
            r_o_wl <= r_have ? r_ws : '0;
            r_o_cv <= r_have;
        end
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wp      <= '0;
            r_tp      <= '0;
            r_fill    <= '0;
            r_ws      <= '0;
            r_above   <= 1'b0;
            r_have    <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_first   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // In the response state a taken result is replaced by the new one.
            if (r_out_vld && i_out_ready && r_state != ST_RESP) r_out_vld <= 1'b0;
            if (r_rd_vld) r_first <= 1'b0;
            r_rd_vld <= (r_state == ST_SCAN);
            unique case (r_state)
                ST_IDLE: begin
                    if (pop) begin
                        unique case (i_q_item.req_type)
                            tsc_pkg::REQ_PUSH: begin
                                r_wp    <= r_wp + 1'b1;
                                r_fill  <= fill_inc;
                                r_above <= above;
                                if (trig) begin
                                    r_tp <= r_wp + 1'b1;
                                    r_ws <= w_clamp;
                                    if (w_clamp <= fill_inc) r_have <= 1'b1;
                                end
                            end
                            tsc_pkg::REQ_COLUMN: begin
                                if (r_have && i_cfg.columns != '0) r_state <= ST_DIV_LO;
                                else r_state <= ST_RESP;
                            end
                            tsc_pkg::REQ_POINT: begin
                                if (r_have) r_state <= ST_PREAD;
                                else r_state <= ST_RESP;
                            end
                            default: r_state <= ST_RESP;
                        endcase
                    end
                end
                ST_DIV_LO: if (div_done) r_state <= ST_DIV_HI;
                ST_DIV_HI: begin
                    if (div_done) begin
                        r_first <= 1'b1;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_off + 1'b1 >= r_end) r_state <= ST_TAIL;
                end
                ST_TAIL:  r_state <= ST_RESP;
                ST_PREAD: r_state <= ST_RESP;
                ST_RESP: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_min_value     = r_o_mn;
    assign o_max_value     = r_o_mx;
    assign o_point_a       = r_o_pa;
    assign o_point_b       = r_o_pb;
    assign o_window_length = r_o_wl;
    assign o_capture_valid = r_o_cv;
endmodule
`default_nettype wire

// File: rtl/triggered_scope_capture.sv
// Top level of the two-channel triggered scope capture block.
//
//  Channel   Direction  Handshake              Contents
//  in        to block   i_in_valid/o_in_ready  push sample pair or a query
//  out       from block o_out_valid/i_out_ready one result per query
//  cfg       to block   i_cfg_we               register index and data
//
// A push is handled in the idle state of the back end. A column query runs
// two serial divisions to find the column bounds, then reads one sample per
// cycle from the store. Reset is synchronous; the stores need no clearing
// because a read beyond the fill count returns zero. A two-entry request
// queue lets requests arrive while the back end is busy or its result is
// not yet taken.
`default_nettype none
module triggered_scope_capture (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [1:0]                   i_req_type,
    input  wire logic signed [23:0]           i_sample_a,
    input  wire logic signed [23:0]           i_sample_b,
    input  wire logic                         i_channel,
    input  wire logic [11:0]                  i_column,
    input  wire logic [12:0]                  i_point_index,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic signed [23:0]                o_min_value,
    output logic signed [23:0]                o_max_value,
    output logic signed [23:0]                o_point_a,
    output logic signed [23:0]                o_point_b,
    output logic [13:0]                       o_window_length,
    output logic                              o_capture_valid,
    input  wire logic                         i_cfg_we,
    input  wire logic [2:0]                   i_cfg_idx,
    input  wire logic [23:0]                  i_cfg_data
);
    tsc_pkg::t_cfg  r_cfg;
    tsc_pkg::t_item in_item, q_item;
    logic q_valid, q_pop;

    // Configuration registers; a write to an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level   <= '0;
            r_cfg.channel <= 1'b0;
            r_cfg.falling <= 1'b0;
            r_cfg.window  <= 14'd1024;
            r_cfg.freeze  <= 1'b0;
            r_cfg.columns <= 13'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tsc_pkg::CFG_LEVEL:   r_cfg.level   <= i_cfg_data;
                tsc_pkg::CFG_CHANNEL: r_cfg.channel <= i_cfg_data[0];
                tsc_pkg::CFG_FALLING: r_cfg.falling <= i_cfg_data[0];
                tsc_pkg::CFG_WINDOW:  r_cfg.window  <= i_cfg_data[13:0];
                tsc_pkg::CFG_FREEZE:  r_cfg.freeze  <= i_cfg_data[0];
                tsc_pkg::CFG_COLUMNS: r_cfg.columns <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    assign in_item.req_type    = i_req_type;
    assign in_item.sample_a    = i_sample_a;
    assign in_item.sample_b    = i_sample_b;
    assign in_item.channel     = i_channel;
    assign in_item.column      = i_column;
    assign in_item.point_index = i_point_index;

    tsc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (in_item),
        .i_freeze  (r_cfg.freeze),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    tsc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (q_valid),
        .i_q_item        (q_item),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_min_value     (o_min_value),
        .o_max_value     (o_max_value),
        .o_point_a       (o_point_a),
        .o_point_b       (o_point_b),
        .o_window_length (o_window_length),
        .o_capture_valid (o_capture_valid)
    );
endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the triggered scope capture block.
`default_nettype none
module tb;
    localparam int unsigned RING      = 8192;
    localparam int unsigned CYC_LIMIT = 4000000;
    localparam int unsigned SETTLE    = 150;

    // One query answer as the block reports it.
    typedef struct packed {
        logic signed [23:0] min_value;
        logic signed [23:0] max_value;
        logic signed [23:0] point_a;
        logic signed [23:0] point_b;
        logic [13:0]        window_length;
        logic               capture_valid;
    } t_scope_answer;

    // Scoreboard: a private copy of the capture state that predicts each query answer.
    class capture_scoreboard;
        logic signed [23:0] ring_a [RING];
        logic signed [23:0] ring_b [RING];
        int unsigned wr_pos, fill, trig_pos, win_size;
        bit above_last, captured;
        logic signed [23:0] level;
        bit watch_b, on_falling, frozen;
        int unsigned win_req, columns;
        t_scope_answer answers_due[$];
        int errors, checked, pushes, queries;

        function void clear();
            foreach (ring_a[i]) begin
                ring_a[i] = '0;
                ring_b[i] = '0;
            end
            wr_pos = 0; fill = 0; trig_pos = 0; win_size = 0;
            above_last = 0; captured = 0;
            level = '0; watch_b = 0; on_falling = 0; frozen = 0;
            win_req = 1024; columns = 1024;
        endfunction

        function void set_reg(logic [2:0] idx, logic [23:0] data);
            case (idx)
                tsc_pkg::CFG_LEVEL:   level = data;
                tsc_pkg::CFG_CHANNEL: watch_b = data[0];
                tsc_pkg::CFG_FALLING: on_falling = data[0];
                tsc_pkg::CFG_WINDOW:  win_req = data[13:0];
                tsc_pkg::CFG_FREEZE:  frozen = data[0];
                tsc_pkg::CFG_COLUMNS: columns = data[12:0];
                default: ;
            endcase
        endfunction

        function logic signed [23:0] window_at(bit chan_b, int unsigned off);
            int unsigned slot;
            if (win_size == 0) return '0;
            if (off > win_size - 1) off = win_size - 1;
            slot = (trig_pos + RING - win_size + off) % RING;
            return chan_b ? ring_b[slot] : ring_a[slot];
        endfunction

        function int pending();
            return answers_due.size();
        endfunction

        // Apply one accepted request; queries leave an expected answer behind.
        function void note_request(tsc_pkg::t_item it);
            t_scope_answer ans;
            logic signed [23:0] watched, v;
            int unsigned w, first, last;
            bit above, hit;
            ans = '0;
            if (it.req_type == tsc_pkg::REQ_PUSH) begin
                if (frozen) return;
                pushes++;
                ring_a[wr_pos] = it.sample_a;
                ring_b[wr_pos] = it.sample_b;
                wr_pos = (wr_pos + 1) % RING;
                if (fill < RING) fill++;
                watched = watch_b ? it.sample_b : it.sample_a;
                above = watched >= level;
                hit = on_falling ? (!above && above_last) : (above && !above_last);
                above_last = above;
                if (hit) begin
                    w = win_req;
                    if (w < 1) w = 1;
                    if (w > RING) w = RING;
                    trig_pos = wr_pos;
                    win_size = w;
                    if (w <= fill) captured = 1;
                end
                return;
            end
            queries++;
            if (it.req_type == tsc_pkg::REQ_COLUMN && captured && columns != 0) begin
                w = win_size;
                first = (it.column * w) / columns;
                last = ((it.column + 1) * w) / columns;
                if (last < first + 1) last = first + 1;
                else if (last > w) last = w;
                ans.min_value = window_at(it.channel, first);
                ans.max_value = ans.min_value;
                for (int unsigned i = first + 1; i < last; i++) begin
                    v = window_at(it.channel, i);
                    if (v < ans.min_value) ans.min_value = v;
                    if (v > ans.max_value) ans.max_value = v;
                end
            end else if (it.req_type == tsc_pkg::REQ_POINT && captured) begin
                ans.point_a = window_at(0, it.point_index);
                ans.point_b = window_at(1, it.point_index);
            end
            ans.window_length = captured ? win_size[13:0] : 14'd0;
            ans.capture_valid = captured;
            answers_due.push_back(ans);
        endfunction

        function void report(string field, int exp_v, int act_v);
            if (exp_v != act_v) begin
                $display("%0t: mismatch on %s: expected %0d, got %0d", $time, field, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(t_scope_answer act);
            t_scope_answer exp_a;
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, act);
                errors++;
                return;
            end
            exp_a = answers_due.pop_front();
            checked++;
            report("min_value", exp_a.min_value, act.min_value);
            report("max_value", exp_a.max_value, act.max_value);
            report("point_a", exp_a.point_a, act.point_a);
            report("point_b", exp_a.point_b, act.point_b);
            report("window_length", exp_a.window_length, act.window_length);
            report("capture_valid", exp_a.capture_valid, act.capture_valid);
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_ready;
    logic [1:0] i_req_type;
    logic signed [23:0] i_sample_a, i_sample_b;
    logic i_channel;
    logic [11:0] i_column;
    logic [12:0] i_point_index;
    logic o_out_valid, i_out_ready;
    logic signed [23:0] o_min_value, o_max_value, o_point_a, o_point_b;
    logic [13:0] o_window_length;
    logic o_capture_valid;
    logic i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [23:0] i_cfg_data;

    triggered_scope_capture DUT (.*);

    capture_scoreboard board;
    bit in_gaps, out_gaps;   // random idling on the request and result sides
    int hold_rx;             // cycles the result side still holds off
    int unsigned cycles;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hung block or a lost result ends the run here.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYC_LIMIT) begin
                $display("%0t: timeout, %0d results still due", $time, board.pending());
                $display("** triggered_scope_capture: FAILED **");
                $finish;
            end
        end
    end

    // Result side: ready changes at the falling edge. A requested hold-off is
    // counted down here so that the request side can keep pushing meanwhile.
    initial begin
        i_out_ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_rx > 0) begin
                i_out_ready = 0;
                hold_rx--;
            end else begin
                i_out_ready = out_gaps ? ($urandom_range(99) >= 38) : 1'b1;
            end
        end
    end

    // Results are sampled at the rising edge, before the block updates.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result('{o_min_value, o_max_value, o_point_a, o_point_b,
                                 o_window_length, o_capture_valid});
    end

    // Offer one request, optionally after random idle cycles, and hold it until
    // it is accepted. Returns at a falling edge, ready for the next request.
    task automatic send_request(tsc_pkg::t_item it);
        while (in_gaps && $urandom_range(99) < 38) begin
            i_in_valid = 0;
            @(negedge i_clk);
        end
        i_req_type = it.req_type;
        i_sample_a = it.sample_a;
        i_sample_b = it.sample_b;
        i_channel = it.channel;
        i_column = it.column;
        i_point_index = it.point_index;
        i_in_valid = 1;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_request(it);
        @(negedge i_clk);
    endtask

    task automatic push(logic signed [23:0] a, logic signed [23:0] b);
        tsc_pkg::t_item it;
        it = '0;
        it.req_type = tsc_pkg::REQ_PUSH;
        it.sample_a = a;
        it.sample_b = b;
        send_request(it);
    endtask

    task automatic query(logic [1:0] kind, bit chan, int col, int pt);
        tsc_pkg::t_item it;
        it = '0;
        it.req_type = kind;
        it.channel = chan;
        it.column = col;
        it.point_index = pt;
        send_request(it);
    endtask

    // Let every expected answer arrive, then give a trailing push time to settle.
    task automatic drain();
        i_in_valid = 0;
        while (board.pending() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] data);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        board.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    // Samples lean toward the extremes and toward the trigger level so that
    // crossings happen often.
    function automatic logic signed [23:0] pick_sample();
        case ($urandom_range(7))
            0: return 24'sh800000;
            1: return 24'sh7fffff;
            2, 3: return board.level + $signed(24'($urandom_range(8))) - 24'sd4;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic tsc_pkg::t_item random_item(int push_pct);
        tsc_pkg::t_item it;
        it = '0;
        it.req_type = ($urandom_range(99) < push_pct) ? tsc_pkg::REQ_PUSH
                                                      : 2'($urandom_range(1, 3));
        it.sample_a = pick_sample();
        it.sample_b = pick_sample();
        it.channel = $urandom_range(1);
        // Columns are mostly inside the count, sometimes anywhere in the field.
        it.column = $urandom_range(3) == 0 ? 12'($urandom) : 12'($urandom_range(24));
        it.point_index = $urandom_range(3) == 0 ? 13'($urandom) : 13'($urandom_range(70));
        return it;
    endfunction

    initial begin
        board = new;
        board.clear();
        in_gaps = 0; out_gaps = 0; hold_rx = 0;
        i_rst_n = 0;
        i_in_valid = 0; i_req_type = '0; i_sample_a = '0; i_sample_b = '0;
        i_channel = 0; i_column = '0; i_point_index = '0;
        i_cfg_we = 0; i_cfg_idx = '0; i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Queries before any capture answer all zeros.
        query(tsc_pkg::REQ_WINDOW, 0, 0, 0);
        query(tsc_pkg::REQ_POINT, 0, 0, 8191);
        query(tsc_pkg::REQ_COLUMN, 1, 0, 0);
        drain();

        // Small window, rising edge on channel A at level zero. The first
        // crossing comes before the stores hold enough samples; the second
        // makes the capture valid.
        write_reg(tsc_pkg::CFG_WINDOW, 24'd4);
        write_reg(tsc_pkg::CFG_COLUMNS, 24'd2);
        push(24'sh800000, 24'sh7fffff);
        push(-24'sd1, 24'sd0);
        push(24'sd0, 24'sh800000);
        push(24'sh7fffff, 24'sd3);
        push(-24'sd5, -24'sd9);
        push(24'sd100, 24'sd7);
        query(tsc_pkg::REQ_COLUMN, 0, 0, 0);
        query(tsc_pkg::REQ_COLUMN, 1, 1, 0);
        query(tsc_pkg::REQ_COLUMN, 0, 4095, 0);
        query(tsc_pkg::REQ_POINT, 0, 0, 0);
        query(tsc_pkg::REQ_POINT, 0, 0, 8191);
        query(tsc_pkg::REQ_WINDOW, 0, 0, 0);
        drain();

        // A column count of zero gives zero min and max; frozen pushes vanish.
        write_reg(tsc_pkg::CFG_COLUMNS, 24'd0);
        write_reg(tsc_pkg::CFG_FREEZE, 24'd1);
        query(tsc_pkg::REQ_COLUMN, 0, 0, 0);
        push(24'sd55, 24'sd66);
        query(tsc_pkg::REQ_POINT, 0, 0, 3);
        drain();

        // Falling edge on channel B at the top level, with a zero window request
        // that clamps to one. Then a later trigger with an oversized request
        // updates the window while the capture stays valid.
        write_reg(tsc_pkg::CFG_FREEZE, 24'd0);
        write_reg(tsc_pkg::CFG_WINDOW, 24'd0);
        write_reg(tsc_pkg::CFG_CHANNEL, 24'd1);
        write_reg(tsc_pkg::CFG_FALLING, 24'd1);
        write_reg(tsc_pkg::CFG_LEVEL, 24'h7fffff);
        push(24'sd1, 24'sh7fffff);
        push(24'sd2, 24'sd0);
        query(tsc_pkg::REQ_POINT, 0, 0, 5);
        drain();
        write_reg(tsc_pkg::CFG_WINDOW, 24'd16383);
        write_reg(tsc_pkg::CFG_COLUMNS, 24'd4096);
        push(24'sd3, 24'sh7fffff);
        push(24'sd4, 24'sh800000);
        query(tsc_pkg::REQ_POINT, 0, 0, 0);
        query(tsc_pkg::REQ_COLUMN, 1, 4095, 0);
        drain();

        // Random phases with a fresh setting each time.
        for (int ph = 0; ph < 9; ph++) begin
            write_reg(tsc_pkg::CFG_LEVEL,
                      ph == 1 ? 24'h800000 : 24'($urandom_range(3) == 0 ? $urandom : 0));
            write_reg(tsc_pkg::CFG_CHANNEL, 24'($urandom_range(1)));
            write_reg(tsc_pkg::CFG_FALLING, 24'($urandom_range(1)));
            write_reg(tsc_pkg::CFG_WINDOW,
                      24'($urandom_range(5) == 0 ? 0 : $urandom_range(1, 64)));
            write_reg(tsc_pkg::CFG_COLUMNS,
                      24'($urandom_range(7) == 0 ? 0 : $urandom_range(1, 16)));
            write_reg(tsc_pkg::CFG_FREEZE, 24'(ph == 6));
            in_gaps = (ph != 2);
            out_gaps = (ph != 2);
            // The result side holds off long enough for the request queue to fill.
            if (ph == 4) hold_rx = 2000;
            for (int n = 0; n < 150; n++) begin
                // The request side also waits once for every answer mid-phase.
                if (ph == 5 && n == 75) drain();
                send_request(random_item(55));
            end
            drain();
        end

        // A short burst under a full-depth window request, then long column scans.
        write_reg(tsc_pkg::CFG_FREEZE, 24'd0);
        write_reg(tsc_pkg::CFG_CHANNEL, 24'd0);
        write_reg(tsc_pkg::CFG_FALLING, 24'd0);
        write_reg(tsc_pkg::CFG_LEVEL, 24'd0);
        write_reg(tsc_pkg::CFG_WINDOW, 24'd8192);
        write_reg(tsc_pkg::CFG_COLUMNS, 24'd4096);
        in_gaps = 0;
        out_gaps = 0;
        for (int n = 0; n < 40; n++) push(pick_sample(), pick_sample());
        in_gaps = 1;
        out_gaps = 1;
        for (int n = 0; n < 60; n++) send_request(random_item(20));
        drain();
        write_reg(tsc_pkg::CFG_COLUMNS, 24'd1);
        query(tsc_pkg::REQ_COLUMN, 0, 0, 0);
        query(tsc_pkg::REQ_COLUMN, 1, 0, 0);
        query(tsc_pkg::REQ_POINT, 1, 0, 8191);
        drain();
        write_reg(tsc_pkg::CFG_COLUMNS, 24'd3);
        for (int n = 0; n < 3; n++) query(tsc_pkg::REQ_COLUMN, $urandom_range(1), n, 0);
        drain();

        $display("Covered %0d stored pushes and %0d queries, %0d answers checked,",
                 board.pushes, board.queries, board.checked);
        $display("over window sizes 1 to 8192, column counts 0 to 4096, both edges and channels.");
        if (board.errors == 0 && board.pending() == 0) begin
            $display("** triggered_scope_capture: PASSED **");
        end else begin
            $display("** triggered_scope_capture: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
